FILE: sv/segment_sphere_hit_test_unit_defines.svh
// Assertion macros used by the segment/sphere hit test checker.
`ifndef SEGMENT_SPHERE_HIT_TEST_UNIT_DEFINES_SVH
`define SEGMENT_SPHERE_HIT_TEST_UNIT_DEFINES_SVH

// Same-cycle implication, sampled on clk_i, off while rst_ni is low.
`define SSHIT_ASSERT_NOW(lbl, pre, post) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |-> (post)) \
    else $error("sshit check failed");

// Next-cycle implication, sampled on clk_i, off while rst_ni is low.
`define SSHIT_ASSERT_NEXT(lbl, pre, post) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error("sshit check failed");

`endif

FILE: sv/sshit_pkg.sv
// Shared types and constants of the segment/sphere hit test unit.
package sshit_pkg;

  localparam int unsigned RadiusWidth = 32;
  localparam int unsigned RadiusFrac  = 16;
  localparam logic [RadiusWidth-1:0] RadiusReset = 32'd2359296;

  // Sign and ordering facts of one test, carried alongside the products.
  typedef struct packed {
    logic l2_nz;
    logic q_pos;
    logic c_neg;
    logic c_zero;
    logic f1_neg;
    logic f1_pos;
    logic q_lt_l2;
  } flags_t;

endpackage

FILE: sv/sshit_mul.sv
// Two-stage signed multiplier built from four half-width partial products.
module sshit_mul #(
  parameter int unsigned W = 70
) (
  input  logic                  clk_i,
  input  logic                  en_i,
  input  logic signed [W-1:0]   a_i,
  input  logic signed [W-1:0]   b_i,
  output logic signed [2*W-1:0] p_o
);

  localparam int unsigned H  = W / 2;
  localparam int unsigned HW = W - H;

  logic signed [HW-1:0]     a_hi, b_hi;
  logic signed [H:0]        a_lo, b_lo;
  logic signed [2*HW-1:0]   hh_d, hh_q;
  logic signed [HW+H:0]     hl_d, hl_q, lh_d, lh_q;
  logic [2*H-1:0]           ll_d, ll_q;
  logic signed [2*W-1:0]    p_d, p_q;

  assign a_hi = a_i[W-1:H];
  assign b_hi = b_i[W-1:H];
  assign a_lo = $signed({1'b0, a_i[H-1:0]});
  assign b_lo = $signed({1'b0, b_i[H-1:0]});

  assign hh_d = a_hi * b_hi;
  assign hl_d = (HW+H+1)'(a_hi) * (HW+H+1)'(b_lo);
  assign lh_d = (HW+H+1)'(a_lo) * (HW+H+1)'(b_hi);
  assign ll_d = a_i[H-1:0] * b_i[H-1:0];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      hh_q <= hh_d;
      hl_q <= hl_d;
      lh_q <= lh_d;
      ll_q <= ll_d;
    end
  end

  // combine the partial products at their weights
  assign p_d = ((2*W)'(hh_q) <<< (2*H))
             + (((2*W)'(hl_q) + (2*W)'(lh_q)) <<< H)
             + (2*W)'($signed({1'b0, ll_q}));

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      p_q <= p_d;
    end
  end

  assign p_o = p_q;

endmodule

FILE: sv/segment_sphere_hit_test_unit.sv
// Top level of the pipelined segment versus sphere hit test unit.
//
// Usage: one transaction on the s_axis channel carries a segment start A,
// a segment end B and a sphere center C, nine signed Q16.16 coordinates of
// COORD_WIDTH bits each. For each accepted transaction the unit returns
// exactly one transaction on the m_axis channel whose tdata bit 0 is hit.
// The squared radius (unsigned Q16.16) is written via cfg_we_i / cfg_wdata_i;
// the user must write it only while no test is in flight (not enforced).
//
// Throughput: one test per cycle unless backpressure holds the pipeline.
// The critical stages are the twelve coordinate products and the two wide
// q*q and c*L2 products; the two wide ones are each split into half-width
// partial products over two stages.
//
// Reset: rst_ni clears all stage valid bits and loads the default radius
// squared of 36.0. Backpressure: when m_axis_tready is low while a result
// is held, the whole pipeline holds; s_axis_tready drops and nothing is
// lost or repeated.
module segment_sphere_hit_test_unit #(
  parameter int unsigned COORD_WIDTH = 32
) (
  input  logic clk_i,
  input  logic rst_ni,

  input  logic                     cfg_we_i,
  input  logic [sshit_pkg::RadiusWidth-1:0] cfg_wdata_i,

  input  logic s_axis_tvalid,
  output logic s_axis_tready,
  // fields from bit 0 up: start_x, start_y, start_z, end_x, end_y, end_z,
  // center_x, center_y, center_z, COORD_WIDTH bits each, zero pad to bytes
  input  logic [((9*COORD_WIDTH+7)/8)*8-1:0] s_axis_tdata,

  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  // fields from bit 0 up: hit, zero pad
  output logic [7:0] m_axis_tdata
);

  import sshit_pkg::*;

  localparam int unsigned CW = COORD_WIDTH;
  localparam int unsigned D  = CW + 1;                 // coordinate difference
  localparam int unsigned PW = 2 * D;                  // one product
  localparam int unsigned SW = (2*D+2 > RadiusWidth+RadiusFrac+2) ?
                               2*D+2 : RadiusWidth+RadiusFrac+2;
  localparam int unsigned NS = 7;                      // pipeline stages

  // Global advance: the pipeline moves whenever the output slot frees up.
  logic          en;
  logic [NS-1:0] vld_q;

  assign en            = !vld_q[NS-1] || m_axis_tready;
  assign s_axis_tready = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[NS-2:0], s_axis_tvalid};
    end
  end

  // Radius register, held in Q16.16.
  logic [RadiusWidth-1:0] rad_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rad_q <= RadiusReset;
    end else if (cfg_we_i) begin
      rad_q <= cfg_wdata_i;
    end
  end

  // Stage 0: capture the coordinates.
  logic signed [CW-1:0] a_q [3];
  logic signed [CW-1:0] b_q [3];
  logic signed [CW-1:0] c_q [3];

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        a_q[k] <= s_axis_tdata[k*CW +: CW];
        b_q[k] <= s_axis_tdata[(3+k)*CW +: CW];
        c_q[k] <= s_axis_tdata[(6+k)*CW +: CW];
      end
    end
  end

  // Stage 1: differences AB, CA and BC. |A-C|^2 equals |C-A|^2.
  logic signed [D-1:0] ab_q [3];
  logic signed [D-1:0] ca_q [3];
  logic signed [D-1:0] bc_q [3];

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        ab_q[k] <= D'(b_q[k]) - D'(a_q[k]);
        ca_q[k] <= D'(c_q[k]) - D'(a_q[k]);
        bc_q[k] <= D'(b_q[k]) - D'(c_q[k]);
      end
    end
  end

  // Stage 2: per-axis products.
  logic signed [PW-1:0] pl_q [3];
  logic signed [PW-1:0] pq_q [3];
  logic signed [PW-1:0] pc_q [3];
  logic signed [PW-1:0] pf_q [3];

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        pl_q[k] <= ab_q[k] * ab_q[k];
        pq_q[k] <= ab_q[k] * ca_q[k];
        pc_q[k] <= ca_q[k] * ca_q[k];
        pf_q[k] <= bc_q[k] * bc_q[k];
      end
    end
  end

  // Stage 3: dot products, radius subtracted in Q32.32.
  logic signed [SW-1:0] rw;
  logic signed [SW-1:0] l2_q, q_q, cc_q, f1_q;

  assign rw = $signed(SW'({rad_q, {RadiusFrac{1'b0}}}));

  always_ff @(posedge clk_i) begin
    if (en) begin
      l2_q <= SW'(pl_q[0]) + SW'(pl_q[1]) + SW'(pl_q[2]);
      q_q  <= SW'(pq_q[0]) + SW'(pq_q[1]) + SW'(pq_q[2]);
      cc_q <= SW'(pc_q[0]) + SW'(pc_q[1]) + SW'(pc_q[2]) - rw;
      f1_q <= SW'(pf_q[0]) + SW'(pf_q[1]) + SW'(pf_q[2]) - rw;
    end
  end

  // Stages 4 and 5: q*q and c*L2; sign flags ride alongside.
  flags_t               flags_d, fl4_q, fl5_q;
  logic signed [2*SW-1:0] qq, cl;

  always_comb begin
    flags_d.l2_nz   = (l2_q != '0);
    flags_d.q_pos   = !q_q[SW-1] && (q_q != '0);
    flags_d.c_neg   = cc_q[SW-1];
    flags_d.c_zero  = (cc_q == '0);
    flags_d.f1_neg  = f1_q[SW-1];
    flags_d.f1_pos  = !f1_q[SW-1] && (f1_q != '0);
    flags_d.q_lt_l2 = (q_q < l2_q);
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      fl4_q <= flags_d;
      fl5_q <= fl4_q;
    end
  end

  sshit_mul #(.W(SW)) u_mul_qq (
    .clk_i (clk_i),
    .en_i  (en),
    .a_i   (q_q),
    .b_i   (q_q),
    .p_o   (qq)
  );

  sshit_mul #(.W(SW)) u_mul_cl (
    .clk_i (clk_i),
    .en_i  (en),
    .a_i   (cc_q),
    .b_i   (l2_q),
    .p_o   (cl)
  );

  // Stage 6: decision.
  logic hit_d, hit_q;

  always_comb begin
    hit_d = 1'b0;
    if (fl5_q.l2_nz) begin
      priority if (fl5_q.c_neg) begin
        hit_d = fl5_q.f1_pos;
      end else if (fl5_q.c_zero) begin
        hit_d = fl5_q.q_pos && fl5_q.f1_pos;
      end else begin
        // start outside: nearer root must be real, positive and inside
        hit_d = fl5_q.q_pos && (qq >= cl) && (fl5_q.q_lt_l2 || fl5_q.f1_neg);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      hit_q <= hit_d;
    end
  end

  assign m_axis_tvalid = vld_q[NS-1];
  assign m_axis_tdata  = {7'b0, hit_q};

endmodule

FILE: sv/segment_sphere_hit_test_unit_checker.sv
// Port-level checker for the segment/sphere hit test unit, with its bind.
`include "segment_sphere_hit_test_unit_defines.svh"

module segment_sphere_hit_test_unit_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       s_axis_tready,
  input logic       m_axis_tvalid,
  input logic       m_axis_tready,
  input logic [7:0] m_axis_tdata
);

  // a held result keeps its value
  `SSHIT_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata))
  // a receiver that takes results never blocks the input
  `SSHIT_ASSERT_NOW(a_ready_flow, m_axis_tready, s_axis_tready)
  // only the hit bit carries information
  `SSHIT_ASSERT_NOW(a_pad_zero, m_axis_tvalid, m_axis_tdata[7:1] == 7'b0)

endmodule

bind segment_sphere_hit_test_unit segment_sphere_hit_test_unit_checker u_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

FILE: dv/segment_sphere_hit_test_unit_tb.sv
// Self-checking testbench of the segment versus sphere hit test unit.
module segment_sphere_hit_test_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CoordWidth = 32;
  localparam int unsigned DataWidth  = ((9*CoordWidth+7)/8)*8;
  // Drain wait: the pipeline depth, plus margin.
  localparam int unsigned DrainCycles = 20;
  localparam int unsigned IdleLimit   = 20000;
  localparam int unsigned LongHold    = 400;
  localparam int unsigned RandomItems = 1400;

  typedef logic signed [CoordWidth-1:0] coord_t;
  typedef logic signed [255:0] wide_t;

  // Expected hit taken from the hit predictor rather than typed in.
  localparam int FromPredictor = -1;

  typedef struct {
    coord_t f[9];
    int     hit;
  } seg_row_t;

  logic clk_i;
  logic rst_ni;
  logic cfg_we_i;
  logic [sshit_pkg::RadiusWidth-1:0] cfg_wdata_i;
  logic s_axis_tvalid;
  logic s_axis_tready;
  // fields from bit 0 up: start_x, start_y, start_z, end_x, end_y, end_z,
  // center_x, center_y, center_z, 32 bits each
  logic [DataWidth-1:0] s_axis_tdata;
  logic m_axis_tvalid;
  logic m_axis_tready;
  // fields from bit 0 up: hit, zero pad
  logic [7:0] m_axis_tdata;

  segment_sphere_hit_test_unit #(
    .COORD_WIDTH(CoordWidth)
  ) DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  // Shadow copy of the radius register and the queue of pending hit flags.
  logic [31:0] radius_sq;
  bit          hit_fifo[$];
  int          mismatches;
  bit          hold_req;
  int          idle_cycles;
  seg_row_t    seg_rows[$];

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Exact decision on the Q32.32 squares, all terms in a 256-bit signed space.
  function automatic bit predict_hit(coord_t f[9], logic [31:0] r2);
    wide_t ab[3], ca[3], ac[3], bc[3];
    wide_t l2, q, cc, f1, rw, qq, cl;
    bit hit;
    l2 = '0; q = '0; cc = '0; f1 = '0;
    hit = 1'b0;
    for (int k = 0; k < 3; k++) begin
      ab[k] = wide_t'(f[3+k]) - wide_t'(f[k]);
      ca[k] = wide_t'(f[6+k]) - wide_t'(f[k]);
      ac[k] = -ca[k];
      bc[k] = wide_t'(f[3+k]) - wide_t'(f[6+k]);
      l2 += ab[k] * ab[k];
      q  += ab[k] * ca[k];
      cc += ac[k] * ac[k];
      f1 += bc[k] * bc[k];
    end
    rw = wide_t'({224'd0, r2}) <<< 16;
    cc -= rw;
    f1 -= rw;
    if (l2 != 0) begin
      if (cc > 0) begin
        if (q > 0) begin
          qq = q * q;
          cl = cc * l2;
          if (qq >= cl) hit = (q < l2) || (f1 < 0);
        end
      end else if (cc < 0) begin
        hit = f1 > 0;
      end else begin
        hit = (q > 0) && (f1 > 0);
      end
    end
    return hit;
  endfunction

  function automatic coord_t fx(int v);
    return coord_t'(v <<< 16);
  endfunction

  function automatic coord_t near_coord(int span_bits);
    return coord_t'($urandom_range(0, (1 << span_bits) - 1)) - coord_t'(1 << (span_bits - 1));
  endfunction

  task automatic add_row(int ax, int ay, int az, int bx, int by, int bz,
                         int cx, int cy, int cz, int hit);
    seg_row_t r;
    r.f = '{fx(ax), fx(ay), fx(az), fx(bx), fx(by), fx(bz), fx(cx), fx(cy), fx(cz)};
    r.hit = hit;
    seg_rows.push_back(r);
  endtask

  // Offer one test and hold it until the block takes it. The handshake is
  // sampled at the falling edge, so acceptance is decided free of races.
  task automatic send_test(coord_t f[9], int hit);
    logic rdy;
    for (int k = 0; k < 9; k++) s_axis_tdata[32*k +: 32] <= f[k];
    s_axis_tvalid <= 1'b1;
    do begin
      @(negedge clk_i);
      rdy = s_axis_tready;
      @(posedge clk_i);
    end while (!rdy);
    hit_fifo.push_back(hit >= 0 ? bit'(hit) : predict_hit(f, radius_sq));
  endtask

  // Drop valid for a random gap once the current burst runs out.
  int burst_left = 0;
  task automatic pace_sender();
    int gap;
    if (burst_left > 0) begin
      burst_left--;
      return;
    end
    burst_left = $urandom_range(0, 20);
    gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // Write the radius register only with the pipeline empty.
  task automatic write_radius(logic [31:0] v);
    s_axis_tvalid <= 1'b0;
    wait (hit_fifo.size() == 0);
    repeat (DrainCycles) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    radius_sq = v;
  endtask

  // Mostly geometry near the sphere, so hits and misses both occur often;
  // some full-range coordinates to toggle every bit.
  function automatic void make_test(output coord_t f[9]);
    int mode;
    coord_t base;
    mode = $urandom_range(0, 99);
    base = (mode < 80) ? near_coord(30) : '0;
    for (int k = 0; k < 9; k++) begin
      if (mode < 60)      f[k] = base + near_coord(21);
      else if (mode < 80) f[k] = base + near_coord(26);
      else                f[k] = coord_t'($urandom());
    end
    // Occasionally collapse the segment or pin the start onto the center.
    if ($urandom_range(0, 29) == 0) for (int k = 0; k < 3; k++) f[3+k] = f[k];
    if ($urandom_range(0, 29) == 0) for (int k = 0; k < 3; k++) f[k] = f[6+k];
  endfunction

  // Receiver: alternate stretches of full readiness with random stalls,
  // and hold off for a long stretch on request.
  initial begin
    int mode_left;
    bit stall_mode;
    mode_left = 0;
    stall_mode = 1'b0;
    m_axis_tready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        m_axis_tready <= 1'b0;
        repeat (LongHold) @(posedge clk_i);
        hold_req = 1'b0;
      end else begin
        if (mode_left == 0) begin
          mode_left  = $urandom_range(16, 96);
          stall_mode = $urandom_range(0, 1);
        end
        mode_left--;
        m_axis_tready <= stall_mode ? ($urandom_range(0, 2) != 0) : 1'b1;
      end
    end
  end

  // Check each result transaction against the oldest expected hit.
  always @(negedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (hit_fifo.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual hit=%0b",
                 $realtime, m_axis_tdata[0]);
        mismatches++;
      end else begin
        bit want;
        want = hit_fifo.pop_front();
        if (m_axis_tdata[0] !== want) begin
          $display("%0t: hit mismatch, expected %0b, actual %0b",
                   $realtime, want, m_axis_tdata[0]);
          mismatches++;
        end
      end
    end
  end

  // Watchdog: end the run when no transaction moves for too long.
  always @(negedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles >= IdleLimit) begin
      $display("Mismatches found");
      $finish;
    end
  end

  initial begin
    logic [31:0] radius_plan[6];
    coord_t f[9];
    mismatches    = 0;
    idle_cycles   = 0;
    hold_req      = 1'b0;
    radius_sq     = sshit_pkg::RadiusReset;
    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_wdata_i   = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed tests at the reset radius of 6.
    add_row(-20, 0, 0,  20, 0, 0,  0, 0, 0, 1);   // straight through the center
    add_row(  5, 5, 5,   5, 5, 5,  5, 5, 5, 0);   // zero-length segment
    add_row(  0, 0, 0,   3, 0, 0,  0, 0, 0, 0);   // inside, ends inside
    add_row(  0, 0, 0,  10, 0, 0,  0, 0, 0, 1);   // inside, leaves the sphere
    add_row(-20, 0, 0, -10, 0, 0,  0, 0, 0, 0);   // stops short of the sphere
    add_row( 10, 0, 0,  20, 0, 0,  0, 0, 0, 0);   // sphere behind the start
    add_row(-20, 10, 0, 20, 10, 0, 0, 0, 0, 0);   // passes beside, no real root
    add_row(  6, 0, 0,  20, 0, 0,  0, 0, 0, 0);   // root at zero, heading away
    add_row( -6, 0, 0,  20, 0, 0,  0, 0, 0, 1);   // root at zero, heading in
    add_row(-20, 0, 0,  -6, 0, 0,  0, 0, 0, 0);   // root exactly at the end
    add_row(-20, 6, 0,  20, 6, 0,  0, 0, 0, FromPredictor);  // tangent
    add_row(-7, -7, -7, 7, 7, 7,   1, 2, 3, FromPredictor);
    foreach (seg_rows[i]) begin
      send_test(seg_rows[i].f, seg_rows[i].hit);
      pace_sender();
    end
    // Coordinate extremes.
    for (int m = 0; m < 4; m++) begin
      for (int k = 0; k < 9; k++)
        f[k] = ((m + k) % 2) ? coord_t'(32'h8000_0000) : coord_t'(32'h7fff_ffff);
      if (m == 3) for (int k = 0; k < 9; k++) f[k] = coord_t'(32'h8000_0000);
      send_test(f, (m == 3) ? 0 : FromPredictor);
    end

    // Random phases over several radius settings, extremes among them.
    radius_plan = '{32'h0000_0000, 32'hffff_ffff, 32'h0001_0000,
                    32'h0064_0000, $urandom(), sshit_pkg::RadiusReset};
    for (int p = 0; p < 6; p++) begin
      write_radius(radius_plan[p]);
      for (int n = 0; n < RandomItems / 6; n++) begin
        // Hold the receiver off once while the sender keeps offering.
        if (p == 2 && n == 50) begin
          hold_req = 1'b1;
          burst_left = 60;
        end
        make_test(f);
        send_test(f, FromPredictor);
        pace_sender();
      end
    end

    s_axis_tvalid <= 1'b0;
    wait (hit_fifo.size() == 0);
    repeat (DrainCycles) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
